FILE: rtl/tbn_pkg.sv
// Shared types, constants and role functions of the tournament barrier node.
`default_nettype none
package tbn_pkg;

  localparam int MaxNodes   = 64;
  localparam int NodeW      = $clog2(MaxNodes);
  localparam int CountW     = $clog2(MaxNodes + 1);
  localparam int MaxRounds  = $clog2(MaxNodes);
  localparam int RoundW     = $clog2(MaxRounds + 2);
  localparam int QueueDepth = 2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_MSG   = 1'b1;

  localparam logic KIND_SEND    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic REG_NUM_NODES = 1'b0;
  localparam logic REG_NODE_ID   = 1'b1;

  typedef enum logic [1:0] {
    ROLE_PASS,
    ROLE_WIN,
    ROLE_LOSE,
    ROLE_TOP
  } role_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ARRIVE,
    PH_RELEASE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_SOLO,
    CMD_ARRIVE,
    CMD_RELEASE
  } cmd_op_t;

  typedef enum logic [1:0] {
    SQ_FETCH,
    SQ_UP,
    SQ_DOWN
  } seq_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [RoundW-1:0] rnd;
  } cmd_t;

  function automatic logic [CountW-1:0] eff_nodes(input logic [CountW-1:0] n);
    logic [CountW-1:0] p;
    p = (n > CountW'(MaxNodes)) ? CountW'(MaxNodes) : n;
    return p;
  endfunction

  function automatic logic [RoundW-1:0] round_count(input logic [CountW-1:0] p);
    logic [RoundW-1:0] r;
    r = RoundW'(MaxRounds);
    for (int j = MaxRounds; j >= 0; j--) begin
      if (((CountW + 1)'(1) << j) >= {1'b0, p}) begin
        r = RoundW'(j);
      end
    end
    return r;
  endfunction

  function automatic role_t role_of(input logic [NodeW-1:0] i, input logic [CountW-1:0] p,
                                    input logic [RoundW-1:0] k);
    logic [CountW:0] h;
    logic [CountW:0] m;
    logic [CountW:0] rem;
    role_t           role;
    h   = (CountW + 1)'(1) << (k - RoundW'(1));
    m   = h << 1;
    rem = {2'b00, i} & (m - (CountW + 1)'(1));
    if (rem == '0) begin
      if (({2'b00, i} + h) >= {1'b0, p}) begin
        role = ROLE_PASS;
      end else begin
        role = (m < {1'b0, p}) ? ROLE_WIN : ROLE_TOP;
      end
    end else if (rem == h) begin
      role = ROLE_LOSE;
    end else begin
      role = ROLE_PASS;
    end
    return role;
  endfunction

  function automatic logic [RoundW-1:0] bit_index(input logic [NodeW-1:0] d);
    logic [RoundW-1:0] e;
    e = '0;
    for (int j = 0; j < NodeW; j++) begin
      if (d[j]) begin
        e = RoundW'(j);
      end
    end
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tbn_front.sv
// Front end: accepts input items and classifies them into commands for the queue.
`default_nettype none
module tbn_front (
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          func,
  input  wire logic [tbn_pkg::NodeW-1:0]     msg_source,
  input  wire logic [tbn_pkg::CountW-1:0]    num_nodes,
  input  wire logic [tbn_pkg::NodeW-1:0]     node_id,
  input  wire logic                          q_full,
  output logic                               q_push,
  output tbn_pkg::cmd_t                      q_cmd
);

  logic [tbn_pkg::CountW-1:0] p;
  logic [tbn_pkg::RoundW-1:0] total;
  logic                       node_ok;
  logic                       above;
  logic [tbn_pkg::NodeW-1:0]  diff;
  logic                       pow2;
  logic [tbn_pkg::RoundW-1:0] k;
  tbn_pkg::role_t             role;
  logic                       keep;

  assign p       = tbn_pkg::eff_nodes(num_nodes);
  assign total   = tbn_pkg::round_count(p);
  assign node_ok = (p >= tbn_pkg::CountW'(2)) && ({1'b0, node_id} < p);
  assign above   = msg_source > node_id;
  assign diff    = above ? (msg_source - node_id) : (node_id - msg_source);
  assign pow2    = (diff != '0) && ((diff & (diff - tbn_pkg::NodeW'(1))) == '0);
  assign k       = tbn_pkg::bit_index(diff) + tbn_pkg::RoundW'(1);
  assign role    = tbn_pkg::role_of(node_id, p, k);

  always_comb begin
    keep      = 1'b0;
    q_cmd.op  = tbn_pkg::CMD_START;
    q_cmd.rnd = k;
    if (func == tbn_pkg::FUNC_START) begin
      keep     = 1'b1;
      q_cmd.op = node_ok ? tbn_pkg::CMD_START : tbn_pkg::CMD_SOLO;
    end else if (node_ok && pow2 && (k <= total)) begin
      if (above) begin
        q_cmd.op = tbn_pkg::CMD_ARRIVE;
        keep     = ({1'b0, msg_source} < p) &&
                   ((role == tbn_pkg::ROLE_WIN) || (role == tbn_pkg::ROLE_TOP));
      end else begin
        q_cmd.op = tbn_pkg::CMD_RELEASE;
        keep     = (role == tbn_pkg::ROLE_LOSE);
      end
    end
  end

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full && keep;

endmodule
`default_nettype wire

FILE: rtl/tbn_queue.sv
// Short command queue between the front end and the round sequencer.
`default_nettype none
module tbn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tbn_pkg::cmd_t cmd_in,
  input  wire logic          pop,
  output tbn_pkg::cmd_t      cmd_out,
  output logic               full,
  output logic               empty
);

  localparam int PtrW = $clog2(tbn_pkg::QueueDepth);
  localparam int CntW = $clog2(tbn_pkg::QueueDepth + 1);

  tbn_pkg::cmd_t   slots [tbn_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(tbn_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(tbn_pkg::QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(tbn_pkg::QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tbn_back.sv
// Back end: walks the barrier rounds one per cycle while results are not stalled and produces result transfers.
`default_nettype none
module tbn_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tbn_pkg::CountW-1:0]    num_nodes,
  input  wire logic [tbn_pkg::NodeW-1:0]     node_id,
  input  wire logic                          q_empty,
  input  wire tbn_pkg::cmd_t                 q_cmd,
  output logic                               q_pop,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               kind,
  output logic [tbn_pkg::NodeW-1:0]          dest_node,
  output logic                               sense_value,
  output logic                               last
);

  tbn_pkg::seq_t              seq;
  tbn_pkg::seq_t              seq_next;
  tbn_pkg::phase_t            phase;
  tbn_pkg::phase_t            phase_next;
  logic [tbn_pkg::RoundW-1:0] cur_round;
  logic [tbn_pkg::RoundW-1:0] cur_round_next;
  logic [tbn_pkg::RoundW-1:0] walk;
  logic [tbn_pkg::RoundW-1:0] walk_next;
  logic                       sense;
  logic                       sense_next;
  logic [tbn_pkg::MaxRounds-1:0] arrived;
  logic [tbn_pkg::MaxRounds-1:0] arrived_next;

  logic [tbn_pkg::CountW-1:0] p;
  logic [tbn_pkg::RoundW-1:0] total;
  logic                       up_done;
  tbn_pkg::role_t             role_up;
  tbn_pkg::role_t             role_dn;
  logic [tbn_pkg::MaxRounds-1:0] mask_up;
  logic [tbn_pkg::MaxRounds-1:0] mask_cmd;
  logic                       hit;
  logic [tbn_pkg::NodeW-1:0]  h_up;
  logic [tbn_pkg::NodeW-1:0]  h_dn;
  logic                       can_emit;
  logic                       cmd_match;

  logic                       emit;
  logic                       e_kind;
  logic [tbn_pkg::NodeW-1:0]  e_dest;
  logic                       e_last;

  assign p        = tbn_pkg::eff_nodes(num_nodes);
  assign total    = tbn_pkg::round_count(p);
  assign up_done  = (walk == '0) || (walk > total);
  assign role_up  = tbn_pkg::role_of(node_id, p, walk);
  assign role_dn  = tbn_pkg::role_of(node_id, p, walk - tbn_pkg::RoundW'(1));
  assign mask_up  = tbn_pkg::MaxRounds'(1) << (walk - tbn_pkg::RoundW'(1));
  assign mask_cmd = tbn_pkg::MaxRounds'(1) << (q_cmd.rnd - tbn_pkg::RoundW'(1));
  assign hit      = |(arrived & mask_up);
  assign h_up     = tbn_pkg::NodeW'(1) << (walk - tbn_pkg::RoundW'(1));
  assign h_dn     = tbn_pkg::NodeW'(1) << (walk - tbn_pkg::RoundW'(2));
  assign can_emit = !result_valid || !result_stall;

  always_comb begin
    unique case (q_cmd.op)
      tbn_pkg::CMD_START,
      tbn_pkg::CMD_SOLO:    cmd_match = (phase == tbn_pkg::PH_IDLE);
      tbn_pkg::CMD_ARRIVE:  cmd_match = (phase == tbn_pkg::PH_ARRIVE) &&
                                        (cur_round == q_cmd.rnd);
      tbn_pkg::CMD_RELEASE: cmd_match = (phase == tbn_pkg::PH_RELEASE) &&
                                        (cur_round == q_cmd.rnd);
      default:              cmd_match = 1'b0;
    endcase
  end

  always_comb begin
    seq_next = seq;
    unique case (seq)
      tbn_pkg::SQ_FETCH: begin
        if (!q_empty && cmd_match) begin
          unique case (q_cmd.op)
            tbn_pkg::CMD_START,
            tbn_pkg::CMD_ARRIVE: seq_next = tbn_pkg::SQ_UP;
            default:             seq_next = tbn_pkg::SQ_DOWN;
          endcase
        end
      end
      tbn_pkg::SQ_UP: begin
        if (up_done) begin
          seq_next = tbn_pkg::SQ_DOWN;
        end else begin
          unique case (role_up)
            tbn_pkg::ROLE_PASS: seq_next = tbn_pkg::SQ_UP;
            tbn_pkg::ROLE_LOSE: seq_next = can_emit ? tbn_pkg::SQ_FETCH : tbn_pkg::SQ_UP;
            tbn_pkg::ROLE_WIN:  seq_next = hit ? tbn_pkg::SQ_UP : tbn_pkg::SQ_FETCH;
            default: begin
              if (!hit) begin
                seq_next = tbn_pkg::SQ_FETCH;
              end else if (can_emit) begin
                seq_next = tbn_pkg::SQ_DOWN;
              end
            end
          endcase
        end
      end
      default: begin
        if ((walk <= tbn_pkg::RoundW'(1)) && can_emit) begin
          seq_next = tbn_pkg::SQ_FETCH;
        end
      end
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    phase_next     = phase;
    cur_round_next = cur_round;
    walk_next      = walk;
    sense_next     = sense;
    arrived_next   = arrived;
    emit           = 1'b0;
    e_kind         = tbn_pkg::KIND_SEND;
    e_dest         = '0;
    e_last         = 1'b0;
    unique case (seq)
      tbn_pkg::SQ_FETCH: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            tbn_pkg::CMD_START,
            tbn_pkg::CMD_SOLO:   walk_next = tbn_pkg::RoundW'(1);
            tbn_pkg::CMD_ARRIVE: begin
              arrived_next = arrived | mask_cmd;
              walk_next    = q_cmd.rnd;
            end
            default:             walk_next = q_cmd.rnd;
          endcase
        end
      end
      tbn_pkg::SQ_UP: begin
        if (up_done) begin
          walk_next = total + tbn_pkg::RoundW'(1);
        end else begin
          unique case (role_up)
            tbn_pkg::ROLE_PASS: walk_next = walk + tbn_pkg::RoundW'(1);
            tbn_pkg::ROLE_LOSE: begin
              if (can_emit) begin
                emit           = 1'b1;
                e_dest         = node_id - h_up;
                e_last         = 1'b1;
                phase_next     = tbn_pkg::PH_RELEASE;
                cur_round_next = walk;
              end
            end
            tbn_pkg::ROLE_WIN: begin
              if (!hit) begin
                phase_next     = tbn_pkg::PH_ARRIVE;
                cur_round_next = walk;
              end else begin
                arrived_next = arrived & ~mask_up;
                walk_next    = walk + tbn_pkg::RoundW'(1);
              end
            end
            default: begin
              if (!hit) begin
                phase_next     = tbn_pkg::PH_ARRIVE;
                cur_round_next = walk;
              end else if (can_emit) begin
                arrived_next = arrived & ~mask_up;
                emit         = 1'b1;
                e_dest       = node_id + h_up;
              end
            end
          endcase
        end
      end
      default: begin
        if (walk > tbn_pkg::RoundW'(1)) begin
          if (role_dn == tbn_pkg::ROLE_WIN) begin
            if (can_emit) begin
              emit      = 1'b1;
              e_dest    = node_id + h_dn;
              walk_next = walk - tbn_pkg::RoundW'(1);
            end
          end else begin
            walk_next = walk - tbn_pkg::RoundW'(1);
          end
        end else if (can_emit) begin
          emit           = 1'b1;
          e_kind         = tbn_pkg::KIND_RELEASE;
          e_last         = 1'b1;
          sense_next     = ~sense;
          phase_next     = tbn_pkg::PH_IDLE;
          cur_round_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= tbn_pkg::SQ_FETCH;
      phase        <= tbn_pkg::PH_IDLE;
      cur_round    <= '0;
      walk         <= '0;
      sense        <= 1'b1;
      arrived      <= '0;
      result_valid <= 1'b0;
    end else begin
      seq       <= seq_next;
      phase     <= phase_next;
      cur_round <= cur_round_next;
      walk      <= walk_next;
      sense     <= sense_next;
      arrived   <= arrived_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= e_kind;
      dest_node   <= e_dest;
      sense_value <= sense;
      last        <= e_last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tournament_barrier_node.sv
// Top level of one tournament barrier node: configuration, front end, queue and back end.
//
//   channel  signals                                   direction
//   item     item_valid/item_stall, func, msg_source   in, stall out
//   result   result_valid/result_stall, kind,
//            dest_node, sense_value, last              out, stall in
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in, ready out
//
// An item is classified in the cycle of its transfer and, unless it is dropped, queued (two entries).
// The sequencer takes a command from the queue, then walks the rounds up or down.
// Results leave from an output register, one per cycle while not stalled.
// Reset is synchronous; the node comes out idle with sense one and no arrivals.
`default_nettype none
module tournament_barrier_node (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          func,
  input  wire logic [tbn_pkg::NodeW-1:0]     msg_source,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic                               kind,
  output logic [tbn_pkg::NodeW-1:0]          dest_node,
  output logic                               sense_value,
  output logic                               last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [tbn_pkg::CountW-1:0]    cfg_data
);

  logic [tbn_pkg::CountW-1:0] num_nodes;
  logic [tbn_pkg::NodeW-1:0]  node_id;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  tbn_pkg::cmd_t              q_in;
  tbn_pkg::cmd_t              q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= tbn_pkg::CountW'(2);
      node_id   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbn_pkg::REG_NUM_NODES: num_nodes <= cfg_data;
        tbn_pkg::REG_NODE_ID:   node_id   <= cfg_data[tbn_pkg::NodeW-1:0];
        default:                num_nodes <= num_nodes;
      endcase
    end
  end

  tbn_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .msg_source (msg_source),
    .num_nodes  (num_nodes),
    .node_id    (node_id),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  tbn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (q_in),
    .pop     (q_pop),
    .cmd_out (q_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  tbn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .num_nodes    (num_nodes),
    .node_id      (node_id),
    .q_empty      (q_empty),
    .q_cmd        (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .dest_node    (dest_node),
    .sense_value  (sense_value),
    .last         (last)
  );

`ifndef NO_ASSERTIONS
  a_release_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == tbn_pkg::KIND_RELEASE)) |-> last)
    else $error("release result without last");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
